// ----- hw/rtl/ost_pkg.sv -----
// Package for the order-statistic table: opcodes, status codes, field widths
// and the sequencer state type. No dependencies.
`timescale 1ns / 1ps

package ost_pkg;

    localparam int OP_W     = 3;
    localparam int KEY_IN_W = 32;
    localparam int TAG_W    = 8;
    localparam int STAT_W   = 3;
    localparam int ANS_W    = 9;

    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
    localparam logic [OP_W-1:0] OP_SELECT = 3'd2;
    localparam logic [OP_W-1:0] OP_RANK   = 3'd3;
    localparam logic [OP_W-1:0] OP_FIND   = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd1;
    localparam logic [STAT_W-1:0] ST_RANGE     = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STAT_W-1:0] ST_DUP       = 3'd4;

    localparam logic [ANS_W-1:0] ANS_MAX = 9'd511;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHIFT_UP,
        S_SHIFT_DN,
        S_SEL,
        S_SEL_WAIT,
        S_NOP
    } t_state;

endpackage

// ----- hw/rtl/order_statistic_table_top.sv -----
// Order-statistic table: sorted key/tag store with insert, delete, select,
// rank and find, run by one sequencer over a simple dual-port memory pair.
// Depends on ost_pkg.
//
//  channel   signals                                   handshake
//  -------   ---------------------------------------   -------------------------
//  command   i_opcode, i_key_or_rank, i_position       start high, busy low
//  result    o_status, o_answer                        o_valid, one cycle, no stall
//
// Scans and shifts walk the memory one entry per cycle. Rank, find, insert and
// delete scan up from the bottom to the first key not below the key; insert
// then shifts the entries above that slot up and delete shifts them down,
// unless the key is a duplicate, the table is full or the key is missing.
// Select reads entry k-1 directly. Synchronous active-low reset empties the
// table at once; the key and tag memories are not cleared. busy drops in the
// cycle that carries the result strobe, so the next command may transfer then.
`timescale 1ns / 1ps

module order_statistic_table_top #(
    parameter int CAPACITY = 256,
    parameter int KEY_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [ost_pkg::OP_W-1:0]       i_opcode,
    input  logic signed [ost_pkg::KEY_IN_W-1:0] i_key_or_rank,
    input  logic [ost_pkg::TAG_W-1:0]      i_position,
    output logic                           o_valid,
    output logic [ost_pkg::STAT_W-1:0]     o_status,
    output logic [ost_pkg::ANS_W-1:0]      o_answer
);
    import ost_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    // key and tag store
    logic signed [KEY_BITS-1:0] mem_key [CAPACITY];
    logic [TAG_W-1:0]           mem_tag [CAPACITY];

    t_state                     r_state, n_state;
    logic [CW-1:0]              r_count, n_count;
    logic [CW-1:0]              r_idx, n_idx;
    logic [CW-1:0]              r_slot, n_slot;
    logic                       r_pend, n_pend;
    logic                       r_hit, n_hit;
    logic [OP_W-1:0]            r_op, n_op;
    logic signed [KEY_BITS-1:0] r_key, n_key;
    logic [TAG_W-1:0]           r_tag, n_tag;
    logic [TAG_W-1:0]           r_found_tag, n_found_tag;
    logic                       r_sel_ok, n_sel_ok;
    logic                       r_valid, n_valid;
    logic [STAT_W-1:0]          r_status, n_status;
    logic [ANS_W-1:0]           r_answer, n_answer;

    logic signed [KEY_BITS-1:0] r_rd_key;
    logic [TAG_W-1:0]           r_rd_tag;

    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    logic signed [KEY_BITS-1:0] mem_wkey;
    logic [TAG_W-1:0]           mem_wtag;
    logic [AW-1:0]              mem_raddr;

    logic signed [KEY_BITS-1:0] key_in;
    logic [KEY_IN_W-1:0]        raw_k;
    logic                       sel_ok_in;
    logic [CW-1:0]              scan_next;
    logic                       scan_ge;
    logic                       scan_end;
    logic [CW-1:0]              scan_slot;
    logic                       full;
    logic                       up_done;
    logic                       up_more;
    logic                       dn_done;
    logic                       dn_more;
    logic [ANS_W-1:0]           rank_ans;

    // Shared decode of the command and of the walk position.
    always_comb begin
        key_in    = KEY_BITS'(i_key_or_rank);
        raw_k     = i_key_or_rank;
        sel_ok_in = !raw_k[KEY_IN_W-1] && (raw_k != '0) && (raw_k <= 32'(r_count));
        scan_next = r_pend ? CW'(r_idx + 1'b1) : r_idx;
        scan_ge   = r_pend && (r_rd_key >= r_key);
        scan_end  = scan_ge || (scan_next >= r_count);
        scan_slot = scan_ge ? r_idx : scan_next;
        full      = (r_count == CW'(CAPACITY));
        up_done   = (r_idx == r_slot);
        up_more   = (CW'(r_idx - 1'b1) > r_slot);
        dn_done   = (CW'(r_idx + 1'b1) >= r_count);
        dn_more   = (32'(r_idx) + 32'd2 < 32'(r_count));
        rank_ans  = (32'(r_slot) > 32'(ANS_MAX)) ? ANS_MAX : ANS_W'(r_slot);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_opcode == OP_SELECT) begin
                        n_state = S_SEL;
                    end else if (i_opcode == OP_INSERT || i_opcode == OP_DELETE ||
                                 i_opcode == OP_RANK || i_opcode == OP_FIND) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_NOP;
                    end
                end
            end
            S_SCAN: begin
                if (scan_end) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (r_op == OP_INSERT && !r_hit && !full) begin
                    n_state = S_SHIFT_UP;
                end else if (r_op == OP_DELETE && r_hit) begin
                    n_state = S_SHIFT_DN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SHIFT_UP: begin
                if (up_done) n_state = S_IDLE;
            end
            S_SHIFT_DN: begin
                if (dn_done) n_state = S_IDLE;
            end
            S_SEL: begin
                n_state = r_sel_ok ? S_SEL_WAIT : S_IDLE;
            end
            S_SEL_WAIT: n_state = S_IDLE;
            S_NOP:      n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Datapath, memory control and result.
    always_comb begin
        n_count     = r_count;
        n_idx       = r_idx;
        n_slot      = r_slot;
        n_pend      = r_pend;
        n_hit       = r_hit;
        n_op        = r_op;
        n_key       = r_key;
        n_tag       = r_tag;
        n_found_tag = r_found_tag;
        n_sel_ok    = r_sel_ok;
        n_valid     = 1'b0;
        n_status    = r_status;
        n_answer    = r_answer;
        mem_we      = 1'b0;
        mem_waddr   = r_idx[AW-1:0];
        mem_wkey    = r_rd_key;
        mem_wtag    = r_rd_tag;
        mem_raddr   = r_idx[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op     = i_opcode;
                    n_key    = key_in;
                    n_tag    = i_position;
                    n_sel_ok = sel_ok_in;
                    n_pend   = 1'b0;
                    n_hit    = 1'b0;
                    // scans start at the bottom; select jumps straight to entry k-1
                    n_idx    = (i_opcode == OP_SELECT && sel_ok_in) ?
                               CW'(raw_k - 32'd1) : '0;
                end
            end
            S_SCAN: begin
                // Read one entry per cycle; stop at the first key not below, or after the last stored key.
                mem_raddr = scan_next[AW-1:0];
                if (scan_end) begin
                    n_slot      = scan_slot;
                    n_hit       = scan_ge && (r_rd_key == r_key);
                    n_found_tag = r_rd_tag;
                    n_pend      = 1'b0;
                end else begin
                    n_idx  = scan_next;
                    n_pend = 1'b1;
                end
            end
            S_DECIDE: begin
                n_pend = 1'b0;
                case (r_op)
                    OP_INSERT: begin
                        n_idx = r_count;
                        if (r_hit) begin
                            n_valid  = 1'b1;
                            n_status = ST_DUP;
                            n_answer = '0;
                        end else if (full) begin
                            n_valid  = 1'b1;
                            n_status = ST_FULL;
                            n_answer = '0;
                        end
                    end
                    OP_DELETE: begin
                        n_idx = r_slot;
                        if (!r_hit) begin
                            n_valid  = 1'b1;
                            n_status = ST_NOT_FOUND;
                            n_answer = '0;
                        end
                    end
                    OP_RANK: begin
                        n_valid  = 1'b1;
                        n_status = ST_OK;
                        n_answer = rank_ans;
                    end
                    default: begin
                        n_valid  = 1'b1;
                        n_status = r_hit ? ST_OK : ST_NOT_FOUND;
                        n_answer = r_hit ? ANS_W'(r_found_tag) : '0;
                    end
                endcase
            end
            S_SHIFT_UP: begin
                // Move entries up by one, top first, then drop the new one in.
                mem_raddr = r_pend ? AW'(r_idx - 2'd2) : AW'(r_idx - 1'b1);
                if (up_done) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_slot[AW-1:0];
                    mem_wkey  = r_key;
                    mem_wtag  = r_tag;
                    n_count   = CW'(r_count + 1'b1);
                    n_valid   = 1'b1;
                    n_status  = ST_OK;
                    n_answer  = '0;
                end else if (!r_pend) begin
                    n_pend = 1'b1;
                end else begin
                    mem_we = 1'b1;
                    n_idx  = CW'(r_idx - 1'b1);
                    n_pend = up_more;
                end
            end
            S_SHIFT_DN: begin
                // Close the gap: move entries down by one, bottom first.
                mem_raddr = r_pend ? AW'(r_idx + 2'd2) : AW'(r_idx + 1'b1);
                if (dn_done) begin
                    n_count  = CW'(r_count - 1'b1);
                    n_valid  = 1'b1;
                    n_status = ST_OK;
                    n_answer = '0;
                end else if (!r_pend) begin
                    n_pend = 1'b1;
                end else begin
                    mem_we = 1'b1;
                    n_idx  = CW'(r_idx + 1'b1);
                    n_pend = dn_more;
                end
            end
            S_SEL: begin
                mem_raddr = r_idx[AW-1:0];
                if (!r_sel_ok) begin
                    n_valid  = 1'b1;
                    n_status = ST_RANGE;
                    n_answer = '0;
                end
            end
            S_SEL_WAIT: begin
                n_valid  = 1'b1;
                n_status = ST_OK;
                n_answer = ANS_W'(r_rd_tag);
            end
            S_NOP: begin
                n_valid  = 1'b1;
                n_status = ST_OK;
                n_answer = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_key[mem_waddr] <= mem_wkey;
            mem_tag[mem_waddr] <= mem_wtag;
        end
        r_rd_key <= mem_key[mem_raddr];
        r_rd_tag <= mem_tag[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_slot      <= n_slot;
        r_hit       <= n_hit;
        r_op        <= n_op;
        r_key       <= n_key;
        r_tag       <= n_tag;
        r_found_tag <= n_found_tag;
        r_sel_ok    <= n_sel_ok;
        r_status    <= n_status;
        r_answer    <= n_answer;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_answer = r_answer;

endmodule

// ----- hw/rtl/ost_checker.sv -----
// Port-level checker for the order-statistic table, bound to the top level.
// Depends on ost_pkg and order_statistic_table_top.
`timescale 1ns / 1ps

module ost_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       o_valid,
    input logic [ost_pkg::STAT_W-1:0] o_status,
    input logic [ost_pkg::ANS_W-1:0]  o_answer
);
    import ost_pkg::*;

    // every accepted command makes the block busy next cycle
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after command transfer");

    // a result marks the end of the work, never the middle of it
    a_valid_ends_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!busy && $past(busy)))
        else $error("result strobe outside end of command");

    a_fall_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("command finished without result");

    a_error_zero_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_answer == '0))
        else $error("nonzero answer with error status");

endmodule

bind order_statistic_table_top ost_checker u_ost_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_status (o_status),
    .o_answer (o_answer)
);
